@@ rtl/ic2d_pkg.sv @@
// Package for the 2-D convolution block: sizes, types, controller states.
// No dependencies.
`default_nettype none
package ic2d_pkg;
    localparam int MaxLine   = 1024;
    localparam int MaxKernel = 7;
    localparam int PixelBits = 16;
    localparam int LineRows  = (MaxKernel > 1) ? MaxKernel - 1 : 1;
    localparam int KSize     = MaxKernel * MaxKernel;
    localparam int ColW      = $clog2(MaxLine);
    localparam int SlotW     = (LineRows > 1) ? $clog2(LineRows) : 1;
    localparam int AddrW     = $clog2(LineRows * MaxLine);
    localparam int KIdxW     = $clog2(KSize);
    localparam int KW        = $clog2(MaxKernel + 1);
    localparam int AccW      = 48;

    localparam logic [2:0] RegRows  = 3'd0;
    localparam logic [2:0] RegCols  = 3'd1;
    localparam logic [2:0] RegKRows = 3'd2;
    localparam logic [2:0] RegKCols = 3'd3;
    localparam logic [2:0] RegScale = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_coeff;
        logic start_pix;
        logic shift_win;
        logic clr_acc;
        logic mac_en;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic mac_last;
        logic emit;
    } sts_t;

    function automatic logic [2:0] fit_kernel(input logic [2:0] k);
        logic [2:0] t;
        t = k | 3'd1;
        if (int'(t) > MaxKernel)
            t = 3'(MaxKernel);
        if (t[0] == 1'b0)
            t = t - 3'd1;
        return t;
    endfunction
endpackage
`default_nettype wire

@@ rtl/ic2d_if.sv @@
// Valid/ready channel interfaces for items, results and register writes.
// No dependencies.
`default_nettype none
interface ic2d_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [5:0]  coeff_index;
    logic signed [15:0] coeff_value;
    logic [15:0] pixel;
    modport source (output valid, action, coeff_index, coeff_value, pixel, input ready);
    modport sink   (input valid, action, coeff_index, coeff_value, pixel, output ready);
endinterface

interface ic2d_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic signed [31:0] out_value;
    logic        frame_last;
    modport source (output valid, out_row, out_col, out_value, frame_last, input ready);
    modport sink   (input valid, out_row, out_col, out_value, frame_last, output ready);
endinterface

interface ic2d_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/ic2d_ctrl.sv @@
// Controller FSM: loads coefficients; takes pixels via read, MAC and output.
// Depends on ic2d_pkg.
`default_nettype none
module ic2d_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_action,
    output logic                 in_ready,
    input  wire logic            out_busy,
    input  wire ic2d_pkg::sts_t  sts,
    output ic2d_pkg::cmd_t       cmd
);
    ic2d_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ic2d_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ic2d_pkg::ST_IDLE:
                if (in_valid && !out_busy && in_action)
                    state_next = ic2d_pkg::ST_READ;
            ic2d_pkg::ST_READ:
                state_next = sts.emit ? ic2d_pkg::ST_MAC : ic2d_pkg::ST_IDLE;
            ic2d_pkg::ST_MAC:
                if (sts.mac_last)
                    state_next = ic2d_pkg::ST_OUT;
            ic2d_pkg::ST_OUT:
                state_next = ic2d_pkg::ST_IDLE;
            default:
                state_next = ic2d_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ic2d_pkg::ST_IDLE:
            begin
                in_ready = !out_busy;
                cmd.load_coeff = in_valid && !out_busy && !in_action;
                cmd.start_pix  = in_valid && !out_busy && in_action;
            end
            ic2d_pkg::ST_READ:
            begin
                cmd.shift_win = 1'b1;
                cmd.clr_acc   = 1'b1;
            end
            ic2d_pkg::ST_MAC:
                cmd.mac_en = 1'b1;
            ic2d_pkg::ST_OUT:
                cmd.finish = 1'b1;
            default:
                cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/ic2d_dp.sv @@
// Datapath: kernel table, line store memory, window, MAC and output register.
// Depends on ic2d_pkg and the channel interfaces.
`default_nettype none
module ic2d_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    ic2d_in_if.sink              in_ch,
    ic2d_out_if.source           out_ch,
    ic2d_cfg_if.sink             cfg_ch,
    input  wire ic2d_pkg::cmd_t  cmd,
    output ic2d_pkg::sts_t       sts,
    output logic                 out_busy
);
    localparam int MK = ic2d_pkg::MaxKernel;
    localparam int LR = ic2d_pkg::LineRows;
    localparam int CW = ic2d_pkg::ColW;
    localparam int SW = ic2d_pkg::SlotW;
    localparam int KI = ic2d_pkg::KIdxW;
    localparam int PixelW = ic2d_pkg::PixelBits;

    logic [12:0] rows_cfg_reg;
    logic [10:0] cols_cfg_reg;
    logic [2:0]  krows_cfg_reg, kcols_cfg_reg;
    logic signed [15:0] scale_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= 13'd1;
            cols_cfg_reg  <= 11'd1;
            krows_cfg_reg <= 3'd3;
            kcols_cfg_reg <= 3'd3;
            scale_reg     <= 16'sd256;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                ic2d_pkg::RegRows:  rows_cfg_reg  <= cfg_ch.data[12:0];
                ic2d_pkg::RegCols:  cols_cfg_reg  <= cfg_ch.data[10:0];
                ic2d_pkg::RegKRows: krows_cfg_reg <= cfg_ch.data[2:0];
                ic2d_pkg::RegKCols: kcols_cfg_reg <= cfg_ch.data[2:0];
                ic2d_pkg::RegScale: scale_reg     <= signed'(cfg_ch.data);
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [12:0] rows_eff;
    logic [10:0] cols_eff;
    logic [2:0]  kr, kc;
    always_comb
    begin
        rows_eff = rows_cfg_reg;
        if (rows_eff == 13'd0) rows_eff = 13'd1;
        if (rows_eff > 13'd4096) rows_eff = 13'd4096;
        cols_eff = cols_cfg_reg;
        if (cols_eff == 11'd0) cols_eff = 11'd1;
        if (cols_eff > 11'(ic2d_pkg::MaxLine)) cols_eff = 11'(ic2d_pkg::MaxLine);
        kr = ic2d_pkg::fit_kernel(krows_cfg_reg);
        kc = ic2d_pkg::fit_kernel(kcols_cfg_reg);
    end

    // kernel table: memory plus a written flag per entry, unwritten reads as zero
    logic signed [15:0] ktab_mem [ic2d_pkg::KSize];
    logic kvalid_reg [ic2d_pkg::KSize];
    logic kload;
    assign kload = cmd.load_coeff && (int'(in_ch.coeff_index) < ic2d_pkg::KSize);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ic2d_pkg::KSize; i++)
                kvalid_reg[i] <= 1'b0;
        end
        else if (kload)
            kvalid_reg[in_ch.coeff_index[KI-1:0]] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (kload)
            ktab_mem[in_ch.coeff_index[KI-1:0]] <= in_ch.coeff_value;
    end

    // position
    logic [11:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [SW-1:0] slot_reg;
    logic [PixelW-1:0] pix_reg;
    logic [12:0] row_inc;
    logic [10:0] col_inc;
    assign row_inc = {1'b0, row_reg} + 13'd1;
    assign col_inc = {1'b0, col_reg} + 11'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cmd.shift_win)
        begin
            if (col_inc >= cols_eff)
            begin
                col_reg <= '0;
                if (row_inc >= rows_eff)
                begin
                    row_reg  <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    row_reg  <= row_inc[11:0];
                    slot_reg <= (int'(slot_reg) == LR - 1) ? '0 : slot_reg + SW'(1);
                end
            end
            else
                col_reg <= col_inc[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_pix)
            pix_reg <= in_ch.pixel[PixelW-1:0];
    end

    // line store: one memory per line row, each read and written at col
    logic [PixelW-1:0] rd_reg [LR];
    genvar g;
    generate
        for (g = 0; g < LR; g++)
        begin : g_line
            logic [PixelW-1:0] mem [ic2d_pkg::MaxLine];
            always_ff @(posedge clk)
            begin
                if (cmd.start_pix)
                    rd_reg[g] <= mem[col_reg];
                if (cmd.shift_win && (int'(slot_reg) == g))
                    mem[col_reg] <= pix_reg;
            end
        end
    endgenerate

    // new window column, oldest line row first
    logic [PixelW-1:0] col_new [MK];
    always_comb
    begin
        int t;
        for (int a = 0; a < MK - 1; a++)
        begin
            t = int'(slot_reg) + LR - (MK - 1 - a);
            if (t >= LR)
                t = t - LR;
            col_new[a] = rd_reg[SW'(t)];
        end
        col_new[MK-1] = pix_reg;
    end

    // window
    logic [PixelW-1:0] win_reg [MK][MK];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < MK; a++)
                for (int b = 0; b < MK; b++)
                    win_reg[a][b] <= '0;
        end
        else if (cmd.shift_win)
        begin
            for (int a = 0; a < MK; a++)
            begin
                for (int b = 0; b < MK - 1; b++)
                    win_reg[a][b] <= win_reg[a][b+1];
                win_reg[a][MK-1] <= col_new[a];
            end
        end
    end

    logic emit_now;
    assign emit_now = ({1'b0, row_reg} < rows_eff) && ({1'b0, col_reg} < cols_eff)
                   && (row_inc >= 13'(kr)) && (col_inc >= 11'(kc));
    assign sts.emit = emit_now;

    // output side info latched at read
    logic [11:0] orow_reg;
    logic [9:0]  ocol_reg;
    logic        olast_reg;
    logic [2:0]  p_reg, s_reg;
    logic [2:0]  p_next, s_next;
    logic signed [ic2d_pkg::AccW-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.shift_win)
        begin
            orow_reg  <= row_reg - 12'(kr >> 1);
            ocol_reg  <= 10'(col_reg) - 10'(kc >> 1);
            olast_reg <= (row_inc >= rows_eff) && (col_inc >= cols_eff);
        end
    end

    // tap counters
    always_comb
    begin
        p_next = p_reg;
        s_next = s_reg;
        if (cmd.clr_acc)
        begin
            p_next = '0;
            s_next = '0;
        end
        else if (cmd.mac_en)
        begin
            if (s_reg == kc - 3'd1)
            begin
                s_next = '0;
                p_next = p_reg + 3'd1;
            end
            else
                s_next = s_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
            s_reg <= '0;
        end
        else
        begin
            p_reg <= p_next;
            s_reg <= s_next;
        end
    end

    // coefficient for the next tap, registered ahead from the next counter values
    logic [KI-1:0] kaddr;
    logic signed [15:0] kdata_reg;
    logic kval_reg;
    assign kaddr = KI'(kr - 3'd1 - p_next) * KI'(MK) + KI'(kc - 3'd1 - s_next);

    always_ff @(posedge clk)
    begin
        if (int'(kaddr) < ic2d_pkg::KSize)
        begin
            kdata_reg <= ktab_mem[kaddr];
            kval_reg  <= kvalid_reg[kaddr];
        end
    end

    // one tap per cycle
    logic [2:0] wr_idx, wc_idx;
    logic [PixelW-1:0] w_sel;
    logic signed [15:0] c_sel;
    logic signed [32:0] prod;
    always_comb
    begin
        wr_idx = 3'(MK) - kr + p_reg;
        wc_idx = 3'(MK) - kc + s_reg;
        w_sel = win_reg[wr_idx][wc_idx];
        c_sel = kval_reg ? kdata_reg : '0;
        prod  = signed'({1'b0, w_sel}) * c_sel;
    end
    assign sts.mac_last = (p_reg == kr - 3'd1) && (s_reg == kc - 3'd1);

    always_ff @(posedge clk)
    begin
        if (cmd.clr_acc)
            acc_reg <= '0;
        else if (cmd.mac_en)
            acc_reg <= acc_reg + ic2d_pkg::AccW'(prod);
    end

    // scale, truncate toward zero, saturate
    logic signed [63:0] sprod;
    logic signed [63:0] q;
    logic signed [31:0] sat;
    always_comb
    begin
        sprod = 64'(acc_reg) * 64'(scale_reg);
        q = (sprod < 0) ? -((-sprod) >>> 8) : (sprod >>> 8);
        if (q > 64'sd2147483647)
            sat = 32'sh7fffffff;
        else if (q < -64'sd2147483648)
            sat = 32'sh80000000;
        else
            sat = q[31:0];
    end

    logic ovalid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.finish)
            ovalid_reg <= 1'b1;
        else if (out_ch.ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_ch.out_row    <= orow_reg;
            out_ch.out_col    <= ocol_reg;
            out_ch.out_value  <= sat;
            out_ch.frame_last <= olast_reg;
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_busy = ovalid_reg && !out_ch.ready;
endmodule
`default_nettype wire

@@ rtl/image_convolution_2d.sv @@
// Top level of the streaming 2-D convolution block.
// Depends on ic2d_pkg, ic2d_if, ic2d_ctrl and ic2d_dp.
//
// channel  dir  carries
// in_ch    in   action, coeff_index, coeff_value, pixel
// out_ch   out  out_row, out_col, out_value, frame_last
// cfg_ch   in   index, data (always ready)
//
// Coefficient load completes in idle. A pixel passes through read and, when it
// yields an output, through MAC and output, one MAC tap per cycle on a shared
// multiplier. Async active-low reset; line store is not cleared.
// A held output stalls input only while out_ch.ready is low.
`default_nettype none
module image_convolution_2d (
    input  wire logic clk,
    input  wire logic rst_n,
    ic2d_in_if.sink   in_ch,
    ic2d_out_if.source out_ch,
    ic2d_cfg_if.sink  cfg_ch
);
    ic2d_pkg::cmd_t cmd;
    ic2d_pkg::sts_t sts;
    logic out_busy;

    ic2d_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_action(in_ch.action), .in_ready(in_ch.ready),
        .out_busy(out_busy), .sts(sts), .cmd(cmd)
    );

    ic2d_dp u_dp (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
        .cmd(cmd), .sts(sts), .out_busy(out_busy)
    );

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load_coeff, cmd.start_pix, cmd.shift_win, cmd.mac_en, cmd.finish}) <= 1)
        else $error("overlapping commands");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_ch.valid)
        else $error("result lost");
    a_pix_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_pix |=> cmd.shift_win)
        else $error("pixel not shifted");
endmodule
`default_nettype wire
